/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

/* rtl/core/psrc_pkg.sv */
// shared constants and types of the point slab region classifier
// no dependencies; used by the point interface and imported by all modules
package psrc_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int COUNT_WIDTH_DEF = 20;
	localparam int MIN_COUNT_RESET = 20;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	typedef enum logic [2:0] {
		REG_P1_X      = 3'd0,
		REG_P1_Y      = 3'd1,
		REG_P1_Z      = 3'd2,
		REG_P2_X      = 3'd3,
		REG_P2_Y      = 3'd4,
		REG_P2_Z      = 3'd5,
		REG_MIN_COUNT = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		REGION_NONE    = 2'd0,
		REGION_FIRST   = 2'd1,
		REGION_SECOND  = 2'd2,
		REGION_BETWEEN = 2'd3
	} region_t;

	// sign of one plane value after the constant-term flip
	typedef struct packed {
		logic pos;
		logic neg;
	} side_t;

endpackage

/* rtl/core/psrc_if.sv */
// valid/ready channel interfaces for points and classification results
// depends on psrc_pkg for default widths
interface psrc_point_if #(
	parameter int COORD_WIDTH = psrc_pkg::COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	logic                          last_point;

	modport source (output valid, output point_x, output point_y, output point_z,
		output last_point, input ready);
	modport sink (input valid, input point_x, input point_y, input point_z,
		input last_point, output ready);
endinterface

interface psrc_result_if ();
	logic       valid;
	logic       ready;
	logic [1:0] region;
	logic [1:0] selected_region;
	logic       is_final;

	modport source (output valid, output region, output selected_region,
		output is_final, input ready);
	modport sink (input valid, input region, input selected_region,
		input is_final, output ready);
endinterface

/* rtl/core/point_slab_region_classifier.sv */
// top level of the point slab region classifier: elastic 5-stage pipeline
// depends on psrc_pkg, psrc_if, psrc_regs, psrc_dot3 and assert_macros.svh
//
//  channel   | dir | handshake          | word
//  ----------+-----+--------------------+------------------------------------------
//  points    | in  | valid/ready        | point_x, point_y, point_z, last_point
//  results   | out | valid/ready        | region, selected_region, is_final
//  apb       | in  | psel/penable/pready| 32-bit registers at 4*index
//
// one word accepted per cycle while the result channel does not hold the chain back
// each point passes the input register, then the products, sums, region and result registers
// ready ripples back combinationally: a stage loads whenever it is empty or its word moves on,
// so a full chain takes a new point in the same cycle its oldest result is taken
// reset clears valid bits, region counters and registers; no memory, no clearing pass
`include "assert_macros.svh"

module point_slab_region_classifier #(
	parameter int COUNT_WIDTH = psrc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [psrc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [psrc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [psrc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	psrc_point_if.sink                         points,
	psrc_result_if.source                      results
);
	import psrc_pkg::*;

	// coordinate width is fixed by the point channel
	localparam int COORD_WIDTH = COORD_WIDTH_DEF;
	localparam int SW = 2 * COORD_WIDTH + 3;
	localparam int EW = SW + 1;

	// configuration
	logic signed [COORD_WIDTH-1:0] p1 [3];
	logic signed [COORD_WIDTH-1:0] p2 [3];
	logic [COUNT_WIDTH-1:0]        min_count;
	logic signed [COORD_WIDTH:0]   dir [3];

	psrc_regs #(
		.COORD_WIDTH (COORD_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.p1        (p1),
		.p2        (p2),
		.min_count (min_count)
	);

	// segment direction p2 - p1, one bit wider so it never wraps
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dir[i] = (COORD_WIDTH + 1)'(p2[i]) - (COORD_WIDTH + 1)'(p1[i]);
		end
	end

	// stage enables: a stage loads when empty or when its word moves on
	logic v1_q, v2_q, v3_q, v4_q, out_v_q;
	logic en1, en2, en3, en4, en_out;

	assign en_out = !out_v_q || results.ready;
	assign en4    = !v4_q || en_out;
	assign en3    = !v3_q || en4;
	assign en2    = !v2_q || en3;
	assign en1    = !v1_q || en2;

	assign points.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			v4_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1)    v1_q    <= points.valid;
			if (en2)    v2_q    <= v1_q;
			if (en3)    v3_q    <= v2_q;
			if (en4)    v4_q    <= v3_q;
			if (en_out) out_v_q <= v4_q;
		end
	end

	// stage 1: input register
	logic signed [COORD_WIDTH-1:0] pt_s1 [3];
	logic last_s1, last_s2, last_s3;

	always_ff @(posedge clk) begin
		if (en1) begin
			pt_s1[0] <= points.point_x;
			pt_s1[1] <= points.point_y;
			pt_s1[2] <= points.point_z;
			last_s1  <= points.last_point;
		end
		if (en2) last_s2 <= last_s1;
		if (en3) last_s3 <= last_s2;
	end

	// stages 2 and 3: d.p for the point; d.p1 and d.p2 track the registers freely, which
	// is safe if the user changes registers only while nothing is in flight; the block does not check
	logic signed [SW-1:0] dp_s3, da_s3, db_s3;

	psrc_dot3 #(.COORD_WIDTH (COORD_WIDTH)) u_dot_pt (
		.clk     (clk),
		.prod_en (en2),
		.sum_en  (en3),
		.d       (dir),
		.v       (pt_s1),
		.sum     (dp_s3)
	);

	psrc_dot3 #(.COORD_WIDTH (COORD_WIDTH)) u_dot_p1 (
		.clk     (clk),
		.prod_en (1'b1),
		.sum_en  (1'b1),
		.d       (dir),
		.v       (p1),
		.sum     (da_s3)
	);

	psrc_dot3 #(.COORD_WIDTH (COORD_WIDTH)) u_dot_p2 (
		.clk     (clk),
		.prod_en (1'b1),
		.sum_en  (1'b1),
		.d       (dir),
		.v       (p2),
		.sum     (db_s3)
	);

	// plane signs: plane 1 is d.p - d.p1, flipped when d.p1 > 0;
	// plane 2 is d.p2 - d.p, flipped when d.p2 < 0
	logic signed [EW-1:0] e1, e2;
	logic    e1_pos, e1_neg, e2_pos, e2_neg, da_pos, db_neg;
	side_t   side1, side2;
	region_t region_d;

	always_comb begin
		e1     = EW'(dp_s3) - EW'(da_s3);
		e2     = EW'(db_s3) - EW'(dp_s3);
		e1_neg = e1[EW-1];
		e1_pos = !e1[EW-1] && (e1 != '0);
		e2_neg = e2[EW-1];
		e2_pos = !e2[EW-1] && (e2 != '0);
		da_pos = !da_s3[SW-1] && (da_s3 != '0);
		db_neg = db_s3[SW-1];

		side1.pos = da_pos ? e1_neg : e1_pos;
		side1.neg = da_pos ? e1_pos : e1_neg;
		side2.pos = db_neg ? e2_neg : e2_pos;
		side2.neg = db_neg ? e2_pos : e2_neg;

		// zero on either plane falls through to none
		if (side1.neg && side2.pos)      region_d = REGION_FIRST;
		else if (side1.pos && side2.neg) region_d = REGION_SECOND;
		else if (side1.pos && side2.pos) region_d = REGION_BETWEEN;
		else                             region_d = REGION_NONE;
	end

	// stage 4: region register
	region_t region_s4;
	logic    last_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			region_s4 <= region_d;
			last_s4   <= last_s3;
		end
	end

	// stage 5: region counters and result register; counters move with the word
	logic [COUNT_WIDTH-1:0] cnt_first_q, cnt_second_q, cnt_between_q;
	logic [COUNT_WIDTH-1:0] cnt_first_d, cnt_second_d, cnt_between_d;
	logic    use_first, use_second, use_between;
	region_t sel_d;
	logic    cnt_adv;

	assign cnt_adv = v4_q && en_out;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	always_comb begin
		cnt_first_d   = (region_s4 == REGION_FIRST)   ? sat_inc(cnt_first_q)   : cnt_first_q;
		cnt_second_d  = (region_s4 == REGION_SECOND)  ? sat_inc(cnt_second_q)  : cnt_second_q;
		cnt_between_d = (region_s4 == REGION_BETWEEN) ? sat_inc(cnt_between_q) : cnt_between_q;

		use_first   = cnt_first_d > min_count;
		use_second  = cnt_second_d > min_count;
		use_between = cnt_between_d > min_count;

		// later choices override earlier ones
		sel_d = REGION_NONE;
		if (use_first)                              sel_d = REGION_FIRST;
		if (use_second)                             sel_d = REGION_SECOND;
		if (use_first && use_second && use_between) sel_d = REGION_BETWEEN;
		if (!last_s4)                               sel_d = REGION_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_first_q   <= '0;
			cnt_second_q  <= '0;
			cnt_between_q <= '0;
		end else if (cnt_adv) begin
			if (last_s4) begin
				cnt_first_q   <= '0;
				cnt_second_q  <= '0;
				cnt_between_q <= '0;
			end else begin
				cnt_first_q   <= cnt_first_d;
				cnt_second_q  <= cnt_second_d;
				cnt_between_q <= cnt_between_d;
			end
		end
	end

	region_t region_q, sel_q;
	logic    final_q;

	always_ff @(posedge clk) begin
		if (en_out) begin
			region_q <= region_s4;
			sel_q    <= sel_d;
			final_q  <= last_s4;
		end
	end

	assign results.valid           = out_v_q;
	assign results.region          = region_q;
	assign results.selected_region = sel_q;
	assign results.is_final        = final_q;

	// a free result slot means the whole chain can advance
	`ASSERT_IMPLIES(a_ready_when_out_free, clk, arst_n, !out_v_q, points.ready)
	// the chosen region only shows on the closing word
	`ASSERT_IMPLIES(a_sel_only_final, clk, arst_n, out_v_q && !final_q, sel_q == REGION_NONE)
	// counters restart after the cloud closes
	`ASSERT_NEXT(a_cnt_cleared, clk, arst_n, cnt_adv && last_s4,
		cnt_first_q <= 1 && cnt_second_q <= 1 && cnt_between_q <= 1)
	// first and between counters never fall inside a cloud
	`ASSERT_NEXT(a_cnt_monotonic, clk, arst_n, cnt_adv && !last_s4,
		cnt_first_q >= $past(cnt_first_q) && cnt_between_q >= $past(cnt_between_q))

endmodule

/* rtl/core/psrc_regs.sv */
// apb register file: segment ends and region count threshold
// depends on psrc_pkg
module psrc_regs #(
	parameter int COORD_WIDTH = psrc_pkg::COORD_WIDTH_DEF,
	parameter int COUNT_WIDTH = psrc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [psrc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [psrc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [psrc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	output logic signed [COORD_WIDTH-1:0]      p1 [3],
	output logic signed [COORD_WIDTH-1:0]      p2 [3],
	output logic [COUNT_WIDTH-1:0]             min_count
);
	import psrc_pkg::*;

	logic signed [COORD_WIDTH-1:0] p1_q [3];
	logic signed [COORD_WIDTH-1:0] p2_q [3];
	logic [COUNT_WIDTH-1:0]        min_count_q;
	logic                          wr_en;
	reg_idx_t                      idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				p1_q[i] <= '0;
				p2_q[i] <= '0;
			end
			min_count_q <= COUNT_WIDTH'(MIN_COUNT_RESET);
		end else if (wr_en) begin
			unique case (idx)
				REG_P1_X:      p1_q[0] <= pwdata[COORD_WIDTH-1:0];
				REG_P1_Y:      p1_q[1] <= pwdata[COORD_WIDTH-1:0];
				REG_P1_Z:      p1_q[2] <= pwdata[COORD_WIDTH-1:0];
				REG_P2_X:      p2_q[0] <= pwdata[COORD_WIDTH-1:0];
				REG_P2_Y:      p2_q[1] <= pwdata[COORD_WIDTH-1:0];
				REG_P2_Z:      p2_q[2] <= pwdata[COORD_WIDTH-1:0];
				REG_MIN_COUNT: min_count_q <= pwdata[COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// readback, zero-extended
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_P1_X:      prdata[COORD_WIDTH-1:0] = p1_q[0];
			REG_P1_Y:      prdata[COORD_WIDTH-1:0] = p1_q[1];
			REG_P1_Z:      prdata[COORD_WIDTH-1:0] = p1_q[2];
			REG_P2_X:      prdata[COORD_WIDTH-1:0] = p2_q[0];
			REG_P2_Y:      prdata[COORD_WIDTH-1:0] = p2_q[1];
			REG_P2_Z:      prdata[COORD_WIDTH-1:0] = p2_q[2];
			REG_MIN_COUNT: prdata[COUNT_WIDTH-1:0] = min_count_q;
			default:       prdata = '0;
		endcase
	end

	assign p1        = p1_q;
	assign p2        = p2_q;
	assign min_count = min_count_q;

endmodule

/* rtl/core/psrc_dot3.sv */
// two-stage 3-term dot product: product registers, then sum register
// depends on psrc_pkg for default widths
module psrc_dot3 #(
	parameter int COORD_WIDTH = psrc_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              prod_en,
	input  logic                              sum_en,
	input  logic signed [COORD_WIDTH:0]       d [3],
	input  logic signed [COORD_WIDTH-1:0]     v [3],
	output logic signed [2*COORD_WIDTH+2:0]   sum
);
	import psrc_pkg::*;

	localparam int PW = 2 * COORD_WIDTH + 1;
	localparam int SW = 2 * COORD_WIDTH + 3;

	logic signed [PW-1:0] prod_s2 [3];
	logic signed [SW-1:0] sum_s3;

	always_ff @(posedge clk) begin
		if (prod_en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= PW'(d[i]) * PW'(v[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum_en) begin
			sum_s3 <= SW'(prod_s2[0]) + SW'(prod_s2[1]) + SW'(prod_s2[2]);
		end
	end

	assign sum = sum_s3;

endmodule

/* tb/psrc_region_checker.sv */
// checker for the point slab region classifier: follows apb writes and both word channels
// keeps its own register copy and region counters, predicts each result word and compares
// depends on psrc_pkg and the channel interfaces of psrc_if
module psrc_region_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [psrc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [psrc_pkg::APB_DATA_W-1:0] pwdata,
	psrc_point_if                           points,
	psrc_result_if                          results,
	output int                              fails,
	output int                              pending
);
	import psrc_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int NW = COUNT_WIDTH_DEF;

	typedef struct packed {
		region_t region;
		region_t selected;
		logic    is_final;
	} verdict_t;

	logic signed [CW-1:0] end1 [3];
	logic signed [CW-1:0] end2 [3];
	logic [NW-1:0]        min_count;
	logic [NW-1:0]        cnt_first;
	logic [NW-1:0]        cnt_second;
	logic [NW-1:0]        cnt_between;
	verdict_t             expected_verdicts [$];
	verdict_t             predicted;
	verdict_t             want;

	function automatic int sign_of(longint v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	function automatic logic [NW-1:0] sat_inc(logic [NW-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	// side of each plane from exact dot products, then region tag and counter update
	function automatic verdict_t classify_point(logic signed [CW-1:0] px,
		logic signed [CW-1:0] py, logic signed [CW-1:0] pz, logic last);
		longint   dir [3];
		longint   pt [3];
		longint   dot_p;
		longint   dot_1;
		longint   dot_2;
		int       s1;
		int       s2;
		verdict_t v;
		pt[0] = px;
		pt[1] = py;
		pt[2] = pz;
		dot_p = 0;
		dot_1 = 0;
		dot_2 = 0;
		for (int i = 0; i < 3; i++) begin
			dir[i] = longint'(end2[i]) - longint'(end1[i]);
			dot_p += dir[i] * pt[i];
			dot_1 += dir[i] * longint'(end1[i]);
			dot_2 += dir[i] * longint'(end2[i]);
		end
		// plane constants are -(d.p1) and d.p2; flip so they are not negative
		s1 = sign_of(dot_p - dot_1);
		if (dot_1 > 0) s1 = -s1;
		s2 = sign_of(dot_2 - dot_p);
		if (dot_2 < 0) s2 = -s2;

		v.region = REGION_NONE;
		if (s1 == -1 && s2 == 1) begin
			v.region = REGION_FIRST;
			cnt_first = sat_inc(cnt_first);
		end else if (s1 == 1 && s2 == -1) begin
			v.region = REGION_SECOND;
			cnt_second = sat_inc(cnt_second);
		end else if (s1 == 1 && s2 == 1) begin
			v.region = REGION_BETWEEN;
			cnt_between = sat_inc(cnt_between);
		end

		v.selected = REGION_NONE;
		v.is_final = last;
		if (last) begin
			if (cnt_first > min_count) v.selected = REGION_FIRST;
			if (cnt_second > min_count) v.selected = REGION_SECOND;
			if (cnt_first > min_count && cnt_second > min_count && cnt_between > min_count)
				v.selected = REGION_BETWEEN;
			cnt_first = '0;
			cnt_second = '0;
			cnt_between = '0;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				end1[i] = '0;
				end2[i] = '0;
			end
			min_count = NW'(MIN_COUNT_RESET);
			cnt_first = '0;
			cnt_second = '0;
			cnt_between = '0;
			expected_verdicts.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
					REG_P1_X:      end1[0] = pwdata[CW-1:0];
					REG_P1_Y:      end1[1] = pwdata[CW-1:0];
					REG_P1_Z:      end1[2] = pwdata[CW-1:0];
					REG_P2_X:      end2[0] = pwdata[CW-1:0];
					REG_P2_Y:      end2[1] = pwdata[CW-1:0];
					REG_P2_Z:      end2[2] = pwdata[CW-1:0];
					REG_MIN_COUNT: min_count = pwdata[NW-1:0];
					default:       ;
				endcase
			end
			if (points.valid && points.ready) begin
				predicted = classify_point(points.point_x, points.point_y,
					points.point_z, points.last_point);
				expected_verdicts.insert(expected_verdicts.size(), predicted);
			end
			if (results.valid && results.ready) begin
				if (expected_verdicts.size() == 0) begin
					if (fails < 10)
						$display("unexpected result word: region %0d selected %0d final %0d",
							results.region, results.selected_region, results.is_final);
					fails++;
				end else begin
					want = expected_verdicts.pop_front();
					if (results.region !== want.region
						|| results.selected_region !== want.selected
						|| results.is_final !== want.is_final) begin
						if (fails < 10)
							$display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
								want.region, want.selected, want.is_final,
								results.region, results.selected_region, results.is_final);
						fails++;
					end
				end
			end
			pending = expected_verdicts.size();
		end
	end

endmodule

/* tb/tb_point_slab_region_classifier.sv */
// testbench top of the point slab region classifier: clock, reset, apb writes and point words
// depends on psrc_pkg, psrc_if, the block itself and psrc_region_checker
module tb_point_slab_region_classifier;
	import psrc_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int NW = COUNT_WIDTH_DEF;
	localparam int CMIN = -(2 ** (CW - 1));
	localparam int CMAX = 2 ** (CW - 1) - 1;
	// index past the last register, writes there must change nothing
	localparam logic [2:0] REG_UNMAPPED = 3'd7;
	localparam int RANDOM_PHASES = 9;
	localparam int POINTS_PER_PHASE = 145;
	// pipeline is 5 deep; give it a few more cycles before touching registers
	localparam int DRAIN_CYCLES = 12;
	// longest legal quiet stretch is a receiver stall
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} coord3_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	psrc_point_if  points_ch ();
	psrc_result_if results_ch ();

	int      fails;
	int      pending;
	int      send_idle;
	int      recv_idle;
	int      stall_cycles;
	int      cloud_left;
	coord3_t seg_a;
	coord3_t seg_b;

	point_slab_region_classifier u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.points  (points_ch),
		.results (results_ch)
	);

	psrc_region_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.points  (points_ch),
		.results (results_ch),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side back-pressure, redrawn every cycle from the current idle share
	initial begin
		results_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			results_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog: any accepted word or register write counts as progress
	always @(posedge clk) begin
		if (!arst_n || (points_ch.valid && points_ch.ready)
			|| (results_ch.valid && results_ch.ready) || (psel && penable && pready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic coord3_t xyz(int x, int y, int z);
		coord3_t c;
		c.x = CW'(x);
		c.y = CW'(y);
		c.z = CW'(z);
		return c;
	endfunction

	// idle shares per phase: sender light and receiver heavy, then swapped, then none
	task automatic set_profile(input int ph);
		case (ph)
			0: begin
				send_idle = 12;
				recv_idle = 81;
			end
			1: begin
				send_idle = 81;
				recv_idle = 12;
			end
			default: begin
				send_idle = 0;
				recv_idle = 0;
			end
		endcase
	endtask

	// setup cycle then access cycle; psel is left high so back-to-back writes stay clean
	task automatic apb_write(input logic [2:0] idx, input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	// all seven registers in one go; coordinates go out sign extended
	task automatic set_segment(input coord3_t a, input coord3_t b, input logic [NW-1:0] th);
		apb_write(REG_P1_X, APB_DATA_W'(a.x));
		apb_write(REG_P1_Y, APB_DATA_W'(a.y));
		apb_write(REG_P1_Z, APB_DATA_W'(a.z));
		apb_write(REG_P2_X, APB_DATA_W'(b.x));
		apb_write(REG_P2_Y, APB_DATA_W'(b.y));
		apb_write(REG_P2_Z, APB_DATA_W'(b.z));
		apb_write(REG_MIN_COUNT, APB_DATA_W'(th));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		seg_a = a;
		seg_b = b;
	endtask

	// one point word; valid stays high across back-to-back words
	task automatic send_point(input coord3_t p, input logic last);
		while ($urandom_range(99) < send_idle) begin
			points_ch.valid <= 1'b0;
			@(posedge clk);
		end
		points_ch.valid <= 1'b1;
		points_ch.point_x <= p.x;
		points_ch.point_y <= p.y;
		points_ch.point_z <= p.z;
		points_ch.last_point <= last;
		@(posedge clk);
		while (!points_ch.ready) @(posedge clk);
	endtask

	// registers may only change with the pipeline empty; the clock ticks first so the
	// checker has already counted the last accepted word
	task automatic wait_drained();
		points_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// coordinate at parameter (k-2)/4 along the segment, usually with a little jitter;
	// k of 2 or 6 without jitter lands exactly on a plane
	function automatic logic signed [CW-1:0] along_axis(logic signed [CW-1:0] a,
		logic signed [CW-1:0] b, int k);
		longint v;
		v = longint'(a) + ((longint'(b) - longint'(a)) * (k - 2)) / 4;
		if ($urandom_range(99) < 75) v += int'($urandom_range(64)) - 32;
		return CW'(v);
	endfunction

	// mostly points near the segment so all regions fill, some anywhere in range
	function automatic coord3_t make_point();
		coord3_t p;
		int      k;
		k = $urandom_range(8);
		if ($urandom_range(99) < 20) begin
			p = {CW'($urandom), CW'($urandom), CW'($urandom)};
		end else begin
			p.x = along_axis(seg_a.x, seg_b.x, k);
			p.y = along_axis(seg_a.y, seg_b.y, k);
			p.z = along_axis(seg_a.z, seg_b.z, k);
		end
		return p;
	endfunction

	// moderate coordinates keep near-segment points inside range, full ones hit every bit
	function automatic coord3_t rand_coord3(logic full);
		coord3_t c;
		if (full) begin
			c = {CW'($urandom), CW'($urandom), CW'($urandom)};
		end else begin
			c.x = CW'(int'($urandom_range(2 ** 21)) - 2 ** 20);
			c.y = CW'(int'($urandom_range(2 ** 21)) - 2 ** 20);
			c.z = CW'(int'($urandom_range(2 ** 21)) - 2 ** 20);
		end
		return c;
	endfunction

	// new segment and threshold: coincident ends, an end at the origin and both threshold
	// extremes show up now and then; small thresholds keep every selection reachable
	task automatic random_setting();
		coord3_t       a;
		coord3_t       b;
		logic [NW-1:0] th;
		int            r;
		a = rand_coord3($urandom_range(99) < 25);
		b = rand_coord3($urandom_range(99) < 25);
		r = $urandom_range(99);
		if (r < 12) b = a;
		else if (r < 24) a = '0;
		else if (r < 32) b = '0;
		r = $urandom_range(99);
		if (r < 10) th = '0;
		else if (r < 18) th = '1;
		else if (r < 26) th = NW'($urandom);
		else th = NW'($urandom_range(6));
		set_segment(a, b, th);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		points_ch.valid = 1'b0;
		points_ch.point_x = '0;
		points_ch.point_y = '0;
		points_ch.point_z = '0;
		points_ch.last_point = 1'b0;
		stall_cycles = 0;
		cloud_left = 0;
		seg_a = '0;
		seg_b = '0;
		set_profile(0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: both ends at the origin, so every point is region none
		send_point(xyz(CMIN, CMIN, CMIN), 1'b0);
		send_point(xyz(CMAX, CMAX, CMAX), 1'b0);
		send_point(xyz(CMIN, CMAX, 0), 1'b0);
		send_point(xyz(0, 0, 0), 1'b1);
		wait_drained();

		// segment along x from -100 to 100, no plane flip, threshold zero
		set_segment(xyz(-100, 5, -7), xyz(100, 5, -7), '0);
		// first side only, then second side only
		send_point(xyz(-500, 5, -7), 1'b0);
		send_point(xyz(-500, 1000, 300), 1'b1);
		send_point(xyz(500, -3, 9), 1'b0);
		send_point(xyz(500, 5, -7), 1'b1);
		// one of each region selects between
		send_point(xyz(-500, 0, 0), 1'b0);
		send_point(xyz(500, 0, 0), 1'b0);
		send_point(xyz(0, 77, -77), 1'b1);
		// points on either plane count nowhere, so between is never usable here
		send_point(xyz(-500, 1, 1), 1'b0);
		send_point(xyz(500, 1, 1), 1'b0);
		send_point(xyz(100, 2, 2), 1'b0);
		send_point(xyz(-100, 3, 3), 1'b1);
		// between alone is not enough for a selection
		send_point(xyz(0, 0, 0), 1'b1);
		// coordinate extremes on both outer sides
		send_point(xyz(CMIN, CMAX, CMIN), 1'b0);
		send_point(xyz(CMAX, CMIN, CMAX), 1'b1);
		wait_drained();

		// widest segment and the largest threshold, plus a write past the register map
		set_segment(xyz(CMIN, CMIN, CMIN), xyz(CMAX, CMAX, CMAX), '1);
		apb_write(REG_UNMAPPED, $urandom);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		send_point(xyz(CMIN, CMIN, CMIN), 1'b0);
		send_point(xyz(CMAX, CMAX, CMAX), 1'b0);
		send_point(xyz(0, 0, 0), 1'b1);
		wait_drained();

		// random clouds; a cloud may run on across a register change
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_profile(ph / 3);
			random_setting();
			for (int n = 0; n < POINTS_PER_PHASE; n++) begin
				if (cloud_left == 0) cloud_left = $urandom_range(25, 1);
				send_point(make_point(), cloud_left == 1);
				cloud_left--;
			end
			wait_drained();
		end

		if (fails == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
